// ===== rtl/act_pkg.sv =====
// Package for the delayed-ACK coalescing table: table size, event and reason
// codes, beat payload types and the per-connection entry record.
// No dependencies; the core, act_update and the bench import it.
package act_pkg;

  // Table geometry
  localparam int NumConn = 256;
  localparam int IdxW    = $clog2(NumConn);

  // Event codes carried in the action field
  localparam logic [1:0] ACT_CREATE    = 2'd0;
  localparam logic [1:0] ACT_RECEIVE   = 2'd1;
  localparam logic [1:0] ACT_PIGGYBACK = 2'd2;
  localparam logic [1:0] ACT_EXPIRY    = 2'd3;

  // Reasons for an emitted ACK
  localparam logic [1:0] RSN_NONE    = 2'd0;
  localparam logic [1:0] RSN_IMM     = 2'd1;
  localparam logic [1:0] RSN_COUNT   = 2'd2;
  localparam logic [1:0] RSN_TIMEOUT = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_DUP     = 2'd1;
  localparam logic [1:0] ERR_MISSING = 2'd2;

  // ACK kinds
  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_EACK = 1'b1;

  // Configuration register indexes
  localparam logic CFG_IGNORE_AR = 1'b0;
  localparam logic CFG_EACK_HOLE = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  conn_id;
    logic [31:0] now;
    logic [2:0]  rx_increment;
    logic        immediate_ack;
    logic [7:0]  implicit_acked;
    logic [1:0]  oow_flags;
    logic [1:0]  ack_bitmaps_nonempty;
    logic [1:0]  rx_bitmap_status;
    logic [7:0]  count_threshold;
    logic [19:0] timeout_ticks;
  } act_in_t;

  typedef struct packed {
    logic        send_ack;
    logic        ack_kind;
    logic [1:0]  ack_reason;
    logic        start_timer;
    logic [31:0] timer_deadline;
    logic        clear_oow;
    logic        clear_implicit;
    logic [15:0] counter_after;
    logic [1:0]  error;
  } act_out_t;

  // One connection's stored record
  typedef struct packed {
    logic [15:0] pending_count;
    logic [7:0]  count_limit;
    logic [19:0] timeout_length;
    logic        timer_running;
    logic [31:0] timer_start;
  } act_entry_t;

  typedef struct packed {
    logic ignore_ar_on_oow;
    logic eack_on_rx_hole;
  } act_cfg_t;

  // Table update produced for one event
  typedef struct packed {
    logic       wr_en;
    logic       set_valid;
    act_entry_t entry;
  } act_upd_t;

endpackage

// ===== rtl/ack_coalescing_table_core.sv =====
// Top level of the delayed-ACK coalescing table: input stage, entry RAM with
// write forwarding, valid bits, result register. Depends on act_pkg,
// act_ram and act_update.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------
//  in_     | into      | in_valid/in_stall  | in_data   (act_in_t)
//  out_    | out of    | out_valid/out_stall| out_data  (act_out_t)
//  cfg_    | into      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One event a cycle sustained while the result channel does not stall; the taking
// edge registers the event and the entry RAM read, and a later edge loads the update
// logic's output into the result register.
// The rate is set by the read-modify-write of the entry RAM, with the last
// write forwarded to the following event.
// Reset clears the valid bits of all entries at once; no clearing pass.
// A stalled result holds the result register and the event behind it.
module ack_coalescing_table_core
  import act_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  act_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output act_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic     cfg_data
);

  localparam int EntryW = $bits(act_entry_t);

  logic                s1_valid_r, s1_valid_nxt;
  act_in_t             s1_item_r;
  logic                out_valid_r, out_valid_nxt;
  act_out_t            out_data_r;
  logic                byp_valid_r;
  logic [IdxW-1:0]     byp_addr_r;
  act_entry_t          byp_data_r;
  logic [NumConn-1:0]  entry_valid_r;
  act_cfg_t            cfg_r;

  logic                in_acc;
  logic                s1_adv;
  logic                wr;
  logic [IdxW-1:0]     in_idx;
  logic [IdxW-1:0]     s1_idx;
  logic [EntryW-1:0]   ram_rd;
  act_entry_t          entry_rd;
  act_out_t            res;
  act_upd_t            upd;

  // Handshakes
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && !(out_valid_r && out_stall);
  assign wr        = s1_adv && upd.wr_en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_idx = IdxW'(in_data.conn_id);
  assign s1_idx = IdxW'(s1_item_r.conn_id);

  // Entry store
  act_ram #(
    .WIDTH(EntryW),
    .DEPTH(NumConn)
  ) u_entry_ram (
    .clk    (clk),
    .wr_en  (wr),
    .wr_addr(s1_idx),
    .wr_data(upd.entry),
    .rd_en  (in_acc),
    .rd_addr(in_idx),
    .rd_data(ram_rd)
  );

  // Forward the last write over the RAM read
  assign entry_rd = (byp_valid_r && (byp_addr_r == s1_idx)) ? byp_data_r : act_entry_t'(ram_rd);

  act_update u_update (
    .item       (s1_item_r),
    .entry      (entry_rd),
    .entry_valid(entry_valid_r[s1_idx]),
    .cfg        (cfg_r),
    .res        (res),
    .upd        (upd)
  );

  // Next-state of the pipeline control
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      byp_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      cfg_r         <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr) begin
        byp_valid_r <= 1'b1;
        if (upd.set_valid) begin
          entry_valid_r[s1_idx] <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IGNORE_AR: cfg_r.ignore_ar_on_oow <= cfg_data;
          CFG_EACK_HOLE: cfg_r.eack_on_rx_hole  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: hold the event, the forwarded write and the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (wr) begin
      byp_addr_r <= s1_idx;
      byp_data_r <= upd.entry;
    end
    if (s1_adv) begin
      out_data_r <= res;
    end
  end

  // Assertions
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result path free");

  a_ack_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.send_ack) |-> (out_data.error == ERR_OK))
    else $error("ACK sent with an error code");

  a_ack_or_timer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.send_ack && out_data.start_timer))
    else $error("ACK and timer start in one result");

  a_event_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |=> s1_valid_r)
    else $error("event lost while result stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

// ===== rtl/act_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module act_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/act_update.sv =====
// Per-event decision logic: turns one event and its connection record into
// the result beat and the record update. Depends on act_pkg.
module act_update
  import act_pkg::*;
(
  input  act_in_t    item,
  input  act_entry_t entry,
  input  logic       entry_valid,
  input  act_cfg_t   cfg,
  output act_out_t   res,
  output act_upd_t   upd
);

  logic        in_range;
  logic [16:0] rx_sum;
  logic [15:0] rx_count;
  logic [15:0] limit2;
  logic        rx_trig;
  logic        eack;
  logic        ar_eff;
  logic [15:0] dec;
  logic [15:0] pb_count;
  logic        expiry_hit;
  logic [31:0] elapsed;
  logic        do_ack;
  logic [1:0]  ack_rsn;

  // Range check of the connection index
  assign in_range = ({24'd0, item.conn_id} < 32'(NumConn));

  // Receive: saturating add and threshold at twice the limit
  assign rx_sum   = {1'b0, entry.pending_count} + 17'(item.rx_increment);
  assign rx_count = rx_sum[16] ? 16'hFFFF : rx_sum[15:0];
  assign limit2   = {7'd0, entry.count_limit, 1'b0};

  // ACK typing from bitmaps and drop flags
  assign rx_trig = cfg.eack_on_rx_hole ? item.rx_bitmap_status[1] : item.rx_bitmap_status[0];
  assign eack    = (item.ack_bitmaps_nonempty != 2'd0) || rx_trig || (item.oow_flags != 2'd0);
  assign ar_eff  = item.immediate_ack && !(cfg.ignore_ar_on_oow && (item.oow_flags != 2'd0));

  // Piggyback: subtract twice the implicit count, floor at zero
  assign dec      = {7'd0, item.implicit_acked, 1'b0};
  assign pb_count = (entry.pending_count >= dec) ? (entry.pending_count - dec) : 16'd0;

  // Expiry: live timer, exact deadline and pending ACKs
  assign elapsed    = item.now - entry.timer_start;
  assign expiry_hit = entry.timer_running && (elapsed == 32'(entry.timeout_length))
                      && (entry.pending_count != 16'd0);

  always_comb begin
    res           = '0;
    upd.wr_en     = 1'b0;
    upd.set_valid = 1'b0;
    upd.entry     = entry;
    do_ack        = 1'b0;
    ack_rsn       = RSN_NONE;

    priority if (!in_range) begin
      res.error = ERR_MISSING;
    end else if (item.action == ACT_CREATE) begin
      if (entry_valid) begin
        res.error         = ERR_DUP;
        res.counter_after = entry.pending_count;
      end else begin
        upd.wr_en                = 1'b1;
        upd.set_valid            = 1'b1;
        upd.entry.pending_count  = 16'd0;
        upd.entry.count_limit    = item.count_threshold;
        upd.entry.timeout_length = item.timeout_ticks;
        upd.entry.timer_running  = 1'b0;
        upd.entry.timer_start    = 32'd0;
      end
    end else if (!entry_valid) begin
      res.error = ERR_MISSING;
    end else begin
      upd.wr_en = 1'b1;
      unique case (item.action)
        ACT_CREATE: begin
          // handled above
        end
        ACT_RECEIVE: begin
          upd.entry.pending_count = rx_count;
          priority if (ar_eff) begin
            do_ack  = 1'b1;
            ack_rsn = RSN_IMM;
          end else if (rx_count >= limit2) begin
            do_ack  = 1'b1;
            ack_rsn = RSN_COUNT;
          end else if (!entry.timer_running) begin
            upd.entry.timer_running = 1'b1;
            upd.entry.timer_start   = item.now;
            res.start_timer         = 1'b1;
            res.timer_deadline      = item.now + 32'(entry.timeout_length);
          end
        end
        ACT_PIGGYBACK: begin
          if (item.oow_flags == 2'd0) begin
            upd.entry.pending_count = pb_count;
            res.clear_implicit      = 1'b1;
          end
          if (upd.entry.pending_count == 16'd0) begin
            upd.entry.timer_running = 1'b0;
          end
        end
        ACT_EXPIRY: begin
          if (expiry_hit) begin
            do_ack  = 1'b1;
            ack_rsn = RSN_TIMEOUT;
          end
        end
        default: begin
        end
      endcase

      // Emit the ACK: clear counter and timer
      if (do_ack) begin
        upd.entry.pending_count = 16'd0;
        upd.entry.timer_running = 1'b0;
        res.send_ack            = 1'b1;
        res.ack_kind            = eack ? KIND_EACK : KIND_ACK;
        res.ack_reason          = ack_rsn;
        res.clear_oow           = eack;
        res.clear_implicit      = 1'b1;
      end
      res.counter_after = upd.entry.pending_count;
    end
  end

endmodule

// ===== bench/ack_coalescing_table_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ack_coalescing_table_core: directed and random event beats,
// predicted in-bench and compared field by field against each result beat.
// Depends on act_pkg and the RTL of the core.
module ack_coalescing_table_core_test
  import act_pkg::*;
();

  localparam int CycleLimit = 200000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  act_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  act_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_index = 1'b0;
  logic     cfg_data  = 1'b0;

  // Predicted registers and connection table
  logic        cfg_ignore_ar = 1'b0;
  logic        cfg_eack_hole = 1'b0;
  bit          entry_live   [NumConn];
  logic [15:0] ack_pending  [NumConn];
  logic [7:0]  ack_limit    [NumConn];
  logic [19:0] ack_timeout  [NumConn];
  bit          timer_live   [NumConn];
  logic [31:0] timer_origin [NumConn];

  act_out_t ack_expect_q [$];
  act_out_t ack_want;

  int send_idle_pct  = 25;
  int recv_stall_pct = 67;
  int cycle_count    = 0;
  int mismatches     = 0;
  int events_sent    = 0;
  int timer_starts   = 0;
  int dup_creates    = 0;
  int missing_hits   = 0;
  int acks_by_reason [4] = '{default: 0};

  ack_coalescing_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, ack_expect_q.size());
      $display("ack_coalescing_table_core_test: errors");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Emit an ACK on entry e: type it, clear the counter and stop the timer
  function automatic void issue_ack(input int e, input logic [1:0] why, input act_in_t ev,
                                    inout act_out_t r);
    logic rx_trig;
    rx_trig = cfg_eack_hole ? ev.rx_bitmap_status[1] : ev.rx_bitmap_status[0];
    r.send_ack       = 1'b1;
    r.ack_kind       = (ev.ack_bitmaps_nonempty != 2'b00 || rx_trig || ev.oow_flags != 2'b00)
                       ? KIND_EACK : KIND_ACK;
    r.ack_reason     = why;
    r.clear_oow      = (r.ack_kind == KIND_EACK);
    r.clear_implicit = 1'b1;
    ack_pending[e]   = '0;
    timer_live[e]    = 1'b0;
    acks_by_reason[why]++;
  endfunction

  // Apply one event to the predicted table and return the result it should give
  function automatic act_out_t coalesce(input act_in_t ev);
    act_out_t    r;
    int          e;
    logic [16:0] sum;
    logic [8:0]  dec;
    logic        imm;
    r = '0;
    e = ev.conn_id;
    if (ev.action == ACT_CREATE) begin
      if (entry_live[e]) begin
        r.counter_after = ack_pending[e];
        r.error         = ERR_DUP;
        dup_creates++;
      end else begin
        entry_live[e]   = 1'b1;
        ack_pending[e]  = '0;
        ack_limit[e]    = ev.count_threshold;
        ack_timeout[e]  = ev.timeout_ticks;
        timer_live[e]   = 1'b0;
        timer_origin[e] = '0;
      end
      return r;
    end
    if (!entry_live[e]) begin
      r.error = ERR_MISSING;
      missing_hits++;
      return r;
    end
    case (ev.action)
      ACT_RECEIVE: begin
        // Saturate at 16 bits; the count trigger keeps the counter far below that
        sum = ack_pending[e] + ev.rx_increment;
        if (sum > 17'hFFFF) sum = 17'hFFFF;
        ack_pending[e] = sum[15:0];
        imm = ev.immediate_ack && !(cfg_ignore_ar && ev.oow_flags != 2'b00);
        if (imm) begin
          issue_ack(e, RSN_IMM, ev, r);
        end else if (sum >= {ack_limit[e], 1'b0}) begin
          issue_ack(e, RSN_COUNT, ev, r);
        end else if (!timer_live[e]) begin
          timer_live[e]    = 1'b1;
          timer_origin[e]  = ev.now;
          r.start_timer    = 1'b1;
          r.timer_deadline = ev.now + {12'd0, ack_timeout[e]};
          timer_starts++;
        end
      end
      ACT_PIGGYBACK: begin
        // Hold the counter while an out-of-window drop is pending
        if (ev.oow_flags == 2'b00) begin
          dec = {ev.implicit_acked, 1'b0};
          ack_pending[e] = (ack_pending[e] >= dec) ? ack_pending[e] - dec : 16'd0;
          r.clear_implicit = 1'b1;
        end
        if (ack_pending[e] == 16'd0) timer_live[e] = 1'b0;
      end
      default: begin
        // Only the live timer at its exact deadline with ACKs pending fires
        if (timer_live[e] && ev.now - timer_origin[e] == {12'd0, ack_timeout[e]} &&
            ack_pending[e] != 16'd0) begin
          issue_ack(e, RSN_TIMEOUT, ev, r);
        end
      end
    endcase
    r.counter_after = ack_pending[e];
    return r;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  // Compare every result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ack_expect_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %0h", $time, out_data);
        mismatches++;
      end else begin
        ack_want = ack_expect_q.pop_front();
        check_field("send_ack", ack_want.send_ack, out_data.send_ack);
        check_field("ack_kind", ack_want.ack_kind, out_data.ack_kind);
        check_field("ack_reason", ack_want.ack_reason, out_data.ack_reason);
        check_field("start_timer", ack_want.start_timer, out_data.start_timer);
        check_field("timer_deadline", ack_want.timer_deadline, out_data.timer_deadline);
        check_field("clear_oow", ack_want.clear_oow, out_data.clear_oow);
        check_field("clear_implicit", ack_want.clear_implicit, out_data.clear_implicit);
        check_field("counter_after", ack_want.counter_after, out_data.counter_after);
        check_field("error", ack_want.error, out_data.error);
      end
    end
  end

  // Present one event beat after a random gap and hold it until taken
  task automatic send_event(input act_in_t ev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ack_expect_q.push_back(coalesce(ev));
    events_sent++;
  endtask

  // Drop valid and wait for every predicted result, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    while (ack_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic ignore_ar, input logic eack_hole);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IGNORE_AR;
    cfg_data  <= ignore_ar;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_ignore_ar = ignore_ar;
    cfg_index <= CFG_EACK_HOLE;
    cfg_data  <= eack_hole;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_eack_hole = eack_hole;
    cfg_valid <= 1'b0;
  endtask

  function automatic act_in_t make_event(input logic [1:0] act, input logic [7:0] conn,
                                         input logic [31:0] t);
    act_in_t ev;
    ev               = '0;
    ev.action        = act;
    ev.conn_id       = conn;
    ev.now           = t;
    ev.timeout_ticks = 20'd1;
    return ev;
  endfunction

  // Field extremes, every event type and the corner cases, registers at reset
  task automatic test_directed_basics();
    act_in_t ev;
    // missing entry for each non-create event
    send_event(make_event(ACT_RECEIVE, 8'd255, 32'd0));
    send_event(make_event(ACT_PIGGYBACK, 8'd255, 32'd0));
    send_event(make_event(ACT_EXPIRY, 8'd255, 32'd0));
    // zero threshold: every receive acks on the count
    ev = make_event(ACT_CREATE, 8'd0, 32'd0);
    send_event(ev);
    ev.count_threshold = 8'd255;
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd0, 32'd5);
    ev.rx_bitmap_status = 2'b01;
    send_event(ev);
    ev.rx_increment     = 3'd7;
    ev.rx_bitmap_status = 2'b10;
    send_event(ev);
    // widest threshold and timeout, deadline wrapping past 2^32
    ev = make_event(ACT_CREATE, 8'd255, 32'hFFFF_FFFF);
    ev.count_threshold = 8'd255;
    ev.timeout_ticks   = 20'hFFFFF;
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd255, 32'hFFFF_FFF0);
    ev.rx_increment = 3'd7;
    send_event(ev);
    ev.now = 32'hFFFF_FFF8;
    send_event(ev);
    send_event(make_event(ACT_CREATE, 8'd255, 32'd0));
    // stale, live and repeated expiry
    send_event(make_event(ACT_EXPIRY, 8'd255, 32'h000F_FFEE));
    ev = make_event(ACT_EXPIRY, 8'd255, 32'h000F_FFEF);
    ev.oow_flags = 2'b11;
    send_event(ev);
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd255, 32'd50);
    ev.rx_increment         = 3'd7;
    ev.immediate_ack        = 1'b1;
    ev.ack_bitmaps_nonempty = 2'b01;
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd255, 32'd100);
    ev.rx_increment = 3'd7;
    send_event(ev);
    // piggyback: held by a drop, applied, saturated to zero
    ev = make_event(ACT_PIGGYBACK, 8'd255, 32'd110);
    ev.implicit_acked = 8'd1;
    ev.oow_flags      = 2'b01;
    send_event(ev);
    ev.oow_flags = 2'b00;
    send_event(ev);
    ev.implicit_acked = 8'd255;
    send_event(ev);
    send_event(make_event(ACT_EXPIRY, 8'd255, 32'd100 + 32'hFFFFF));
    send_event(make_event(ACT_PIGGYBACK, 8'd255, 32'd120));
    // immediate request with a drop while not ignored, then a plain one
    ev = make_event(ACT_RECEIVE, 8'd0, 32'd200);
    ev.rx_increment  = 3'd7;
    ev.immediate_ack = 1'b1;
    ev.oow_flags     = 2'b10;
    send_event(ev);
    ev.oow_flags = 2'b00;
    send_event(ev);
    // count trigger reached exactly at twice the threshold
    ev = make_event(ACT_CREATE, 8'd128, 32'd300);
    ev.count_threshold = 8'd2;
    ev.timeout_ticks   = 20'd5;
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd128, 32'd301);
    ev.rx_increment = 3'd3;
    send_event(ev);
    ev.rx_increment = 3'd1;
    send_event(ev);
  endtask

  // Both registers set: ignored requests on drops, EACK on receive holes only
  task automatic test_config_effects();
    act_in_t ev;
    settle();
    set_config(1'b1, 1'b1);
    ev = make_event(ACT_CREATE, 8'd10, 32'd100);
    ev.count_threshold = 8'd3;
    ev.timeout_ticks   = 20'd20;
    send_event(ev);
    ev = make_event(ACT_RECEIVE, 8'd10, 32'd100);
    ev.rx_increment  = 3'd1;
    ev.immediate_ack = 1'b1;
    ev.oow_flags     = 2'b01;
    send_event(ev);
    ev.oow_flags        = 2'b00;
    ev.rx_bitmap_status = 2'b01;
    send_event(ev);
    ev.rx_bitmap_status = 2'b10;
    send_event(ev);
    ev.rx_increment     = 3'd7;
    ev.rx_bitmap_status = 2'b00;
    ev.oow_flags        = 2'b10;
    send_event(ev);
    // timer started with nothing pending; its expiry does nothing
    ev = make_event(ACT_CREATE, 8'd20, 32'd0);
    ev.count_threshold = 8'd1;
    ev.timeout_ticks   = 20'd3;
    send_event(ev);
    send_event(make_event(ACT_RECEIVE, 8'd20, 32'd10));
    send_event(make_event(ACT_EXPIRY, 8'd20, 32'd13));
  endtask

  // Mostly well-formed traffic on a small pool of connections, some raw noise
  task automatic test_random(input int send_pct, input int recv_pct, input logic ignore_ar,
                             input logic eack_hole, input int count);
    act_in_t     ev;
    logic [95:0] noise;
    logic [7:0]  pool [8];
    logic [31:0] tick;
    int          n;
    settle();
    set_config(ignore_ar, eack_hole);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    foreach (pool[k]) pool[k] = $urandom_range(255);
    tick = $urandom();
    for (n = 0; n < count; n++) begin
      // hold off once mid-phase until every result is home
      if (n == count / 2) settle();
      tick += $urandom_range(40);
      ev = make_event($urandom_range(3), pool[$urandom_range(7)], tick);
      ev.rx_increment         = $urandom_range(7);
      ev.immediate_ack        = ($urandom_range(99) < 15);
      ev.implicit_acked       = ($urandom_range(3) == 0) ? $urandom_range(255)
                                                         : $urandom_range(3);
      ev.oow_flags            = ($urandom_range(99) < 70) ? 2'b00 : $urandom_range(3);
      ev.ack_bitmaps_nonempty = $urandom_range(3);
      ev.rx_bitmap_status     = $urandom_range(3);
      ev.count_threshold      = ($urandom_range(9) == 0) ? $urandom_range(255)
                                                         : $urandom_range(6);
      ev.timeout_ticks        = ($urandom_range(9) == 0) ? $urandom_range(20'hFFFFF, 1)
                                                         : $urandom_range(60, 1);
      // steer towards creates on new entries and expiries that hit their deadline
      if (!entry_live[ev.conn_id]) begin
        if ($urandom_range(3) != 0) ev.action = ACT_CREATE;
      end else if (ev.action == ACT_CREATE && $urandom_range(3) != 0) begin
        ev.action = ACT_RECEIVE;
      end else if (ev.action == ACT_EXPIRY && timer_live[ev.conn_id] &&
                   $urandom_range(3) != 0) begin
        ev.now = timer_origin[ev.conn_id] + {12'd0, ack_timeout[ev.conn_id]};
      end
      if ($urandom_range(99) < 8) begin
        noise = {$urandom(), $urandom(), $urandom()};
        ev    = noise[$bits(act_in_t)-1:0];
        if (ev.timeout_ticks == 20'd0) ev.timeout_ticks = 20'd1;
      end
      send_event(ev);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_basics();
    test_config_effects();
    test_random(25, 67, 1'b1, 1'b0, 370);
    test_random(67, 25, 1'b0, 1'b1, 370);
    test_random(0, 0, 1'b0, 1'b0, 370);
    settle();
    $display("%0d events under four register settings; ACKs: %0d immediate, %0d count, %0d timeout",
             events_sent, acks_by_reason[RSN_IMM], acks_by_reason[RSN_COUNT],
             acks_by_reason[RSN_TIMEOUT]);
    $display("%0d timer starts, %0d duplicate creates, %0d missing-entry events",
             timer_starts, dup_creates, missing_hits);
    if (mismatches == 0) begin
      $display("ack_coalescing_table_core_test: clean");
    end else begin
      $display("ack_coalescing_table_core_test: errors");
    end
    $finish;
  end

endmodule
